/* sv/sbcm_pkg.sv */
// Shared types, constants and the arctangent table for the sky box cell test.
// Used by every module of sky_box_cell_membership; no dependencies.
`default_nettype none
package sbcm_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int STAGE_W      = 5;
  localparam int ACC_W        = 34;
  localparam int MAX_CELLS    = 1024;
  localparam int CNT_W        = 11;
  localparam int IDX_W        = 10;

  localparam logic signed [ACC_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [ACC_W-1:0] CORDIC_K = 34'sd652032874;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // configuration register indexes
  localparam logic [3:0] REG_CENTER_LON     = 4'd0;
  localparam logic [3:0] REG_CENTER_LAT     = 4'd1;
  localparam logic [3:0] REG_HALF_WIDTH_LON = 4'd2;
  localparam logic [3:0] REG_HALF_WIDTH_LAT = 4'd3;
  localparam logic [3:0] REG_CELL_INDEX_LON = 4'd4;
  localparam logic [3:0] REG_CELL_COUNT_LON = 4'd5;
  localparam logic [3:0] REG_CELL_INDEX_LAT = 4'd6;
  localparam logic [3:0] REG_CELL_COUNT_LAT = 4'd7;

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } cordic_t;

  // derived box values, held by the configuration block
  typedef struct packed {
    logic               ok;
    logic               last_lon;
    logic               last_lat;
    logic signed [31:0] sb_lon;
    logic signed [31:0] se_lon;
    logic signed [31:0] sb_lat;
    logic signed [31:0] se_lat;
    logic signed [31:0] cv;
    logic signed [31:0] sv;
  } box_t;

  function automatic logic signed [ACC_W-1:0] atan_at(input logic [STAGE_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return $signed({2'b00, a});
  endfunction

  // lower edge inclusive, upper edge exclusive except in the last cell
  function automatic logic in_cell(input logic signed [63:0] v,
                                   input logic signed [31:0] sb,
                                   input logic signed [31:0] se,
                                   input logic last);
    logic signed [63:0] b;
    logic signed [63:0] e;
    b = 64'(sb);
    e = 64'(se);
    return (v >= b) && (last ? (v <= e) : (v < e));
  endfunction

endpackage
`default_nettype wire

/* sv/sbcm_cordic_cell.sv */
// One rotation step of the sine/cosine chain, registered.
// Depends on sbcm_pkg for the step word and arctangent table.
`default_nettype none
module sbcm_cordic_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [sbcm_pkg::STAGE_W-1:0]  stage,
  input  wire sbcm_pkg::cordic_t             d,
  output sbcm_pkg::cordic_t                  q
);

  sbcm_pkg::cordic_t q_next;
  logic signed [sbcm_pkg::ACC_W-1:0] dx;
  logic signed [sbcm_pkg::ACC_W-1:0] dy;
  logic signed [sbcm_pkg::ACC_W-1:0] da;

  always_comb begin
    dx = d.y >>> stage;
    dy = d.x >>> stage;
    da = sbcm_pkg::atan_at(stage);
    q_next = d;
    if (!d.z[sbcm_pkg::ACC_W-1]) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - da;
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
    if (en) begin
      q.neg <= q_next.neg;
      q.x   <= q_next.x;
      q.y   <= q_next.y;
      q.z   <= q_next.z;
    end
  end

endmodule
`default_nettype wire

/* sv/sbcm_cordic_chain.sv */
// Sine and cosine of a binary angle: range fold, a row of 30 rotation cells, clamp.
// Depends on sbcm_pkg and sbcm_cordic_cell. The cells advance only while enabled.
`default_nettype none
module sbcm_cordic_chain (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] angle,
  output logic             out_valid,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  sbcm_pkg::cordic_t link [sbcm_pkg::CORDIC_STEPS+1];
  sbcm_pkg::cordic_t head;
  logic [31:0] folded;
  logic        fold;
  logic signed [sbcm_pkg::ACC_W-1:0] xc;
  logic signed [sbcm_pkg::ACC_W-1:0] yc;

  // fold the left half-plane onto the right one and negate at the end
  always_comb begin
    fold   = (angle > sbcm_pkg::QUARTER_TURN) && (angle < sbcm_pkg::THREE_QUARTER_TURN);
    folded = fold ? angle - sbcm_pkg::HALF_TURN : angle;
    head.valid = in_valid;
    head.neg   = fold;
    head.x     = sbcm_pkg::CORDIC_K;
    head.y     = '0;
    head.z     = sbcm_pkg::ACC_W'($signed(folded));
  end

  assign link[0] = head;

  for (genvar g = 0; g < sbcm_pkg::CORDIC_STEPS; g++) begin : g_cell
    sbcm_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .stage (sbcm_pkg::STAGE_W'(g)),
      .d     (link[g]),
      .q     (link[g+1])
    );
  end

  always_comb begin
    xc = link[sbcm_pkg::CORDIC_STEPS].x;
    yc = link[sbcm_pkg::CORDIC_STEPS].y;
    if (xc > sbcm_pkg::ONE_Q30) xc = sbcm_pkg::ONE_Q30;
    if (xc < -sbcm_pkg::ONE_Q30) xc = -sbcm_pkg::ONE_Q30;
    if (yc > sbcm_pkg::ONE_Q30) yc = sbcm_pkg::ONE_Q30;
    if (yc < -sbcm_pkg::ONE_Q30) yc = -sbcm_pkg::ONE_Q30;
    if (link[sbcm_pkg::CORDIC_STEPS].neg) begin
      xc = -xc;
      yc = -yc;
    end
    out_valid = link[sbcm_pkg::CORDIC_STEPS].valid;
    cos_q     = xc[31:0];
    sin_q     = yc[31:0];
  end

endmodule
`default_nettype wire

/* sv/sbcm_cfg.sv */
// Configuration registers and the sequencer that derives cell edge sines and
// the center rotation. Depends on sbcm_pkg and sbcm_cordic_chain.
`default_nettype none
module sbcm_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [3:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output logic             busy,
  output logic [31:0]      center_lon,
  output sbcm_pkg::box_t   box
);

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_TRIG = 2'd2;
  localparam logic [1:0] PH_IDLE = 2'd3;
  localparam int DVD_W = 43;

  logic [31:0] center_lat;
  logic [30:0] hw_lon;
  logic [30:0] hw_lat;
  logic [sbcm_pkg::IDX_W-1:0] idx_lon;
  logic [sbcm_pkg::CNT_W-1:0] cnt_lon;
  logic [sbcm_pkg::IDX_W-1:0] idx_lat;
  logic [sbcm_pkg::CNT_W-1:0] cnt_lat;

  logic [1:0]        phase;
  logic [1:0]        job;
  logic [5:0]        step;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  dvd_next;
  logic [10:0]       rem;
  logic [10:0]       rem_next;
  logic [11:0]       rem_sh;
  logic              ge;
  logic [30:0]       hw_sel;
  logic [sbcm_pkg::CNT_W-1:0] cnt_sel;
  logic [sbcm_pkg::CNT_W-1:0] mul_sel;
  logic [DVD_W-1:0]  prod;
  logic [31:0]       edge_ang [4];
  logic [31:0]       feed_ang;
  logic              feed;
  logic              t_valid;
  logic signed [31:0] t_sin;
  logic signed [31:0] t_cos;
  logic signed [31:0] sb_lon;
  logic signed [31:0] se_lon;
  logic signed [31:0] sb_lat;
  logic signed [31:0] se_lat;
  logic signed [31:0] cv;
  logic signed [31:0] sv;

  always_comb begin
    hw_sel  = job[1] ? hw_lat : hw_lon;
    cnt_sel = job[1] ? cnt_lat : cnt_lon;
    mul_sel = {1'b0, (job[1] ? idx_lat : idx_lon)} + sbcm_pkg::CNT_W'(job[0]);
    prod    = DVD_W'({hw_sel, 1'b0}) * DVD_W'(mul_sel);
    rem_sh  = {rem, dvd[DVD_W-1]};
    ge      = rem_sh >= {1'b0, cnt_sel};
    rem_next = ge ? 11'(rem_sh - {1'b0, cnt_sel}) : rem_sh[10:0];
    dvd_next = {dvd[DVD_W-2:0], ge};
    feed     = (phase == PH_TRIG) && (step < 6'd5);
    feed_ang = (step[2:0] == 3'd4) ? center_lat : edge_ang[step[1:0]];
  end

  sbcm_cordic_chain u_trig (
    .clk       (clk),
    .rst       (rst),
    .en        (1'b1),
    .in_valid  (feed),
    .angle     (feed_ang),
    .out_valid (t_valid),
    .sin_q     (t_sin),
    .cos_q     (t_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center_lon <= '0;
      center_lat <= '0;
      hw_lon     <= '0;
      hw_lat     <= '0;
      idx_lon    <= '0;
      cnt_lon    <= sbcm_pkg::CNT_W'(1);
      idx_lat    <= '0;
      cnt_lat    <= sbcm_pkg::CNT_W'(1);
      phase      <= PH_LOAD;
      job        <= '0;
      step       <= '0;
    end else if (wr_en) begin
      case (wr_index)
        sbcm_pkg::REG_CENTER_LON:     center_lon <= wr_data;
        sbcm_pkg::REG_CENTER_LAT:     center_lat <= wr_data;
        sbcm_pkg::REG_HALF_WIDTH_LON: hw_lon     <= wr_data[30:0];
        sbcm_pkg::REG_HALF_WIDTH_LAT: hw_lat     <= wr_data[30:0];
        sbcm_pkg::REG_CELL_INDEX_LON: idx_lon    <= wr_data[sbcm_pkg::IDX_W-1:0];
        sbcm_pkg::REG_CELL_COUNT_LON: cnt_lon    <= wr_data[sbcm_pkg::CNT_W-1:0];
        sbcm_pkg::REG_CELL_INDEX_LAT: idx_lat    <= wr_data[sbcm_pkg::IDX_W-1:0];
        sbcm_pkg::REG_CELL_COUNT_LAT: cnt_lat    <= wr_data[sbcm_pkg::CNT_W-1:0];
        default: ;
      endcase
      // recompute everything derived
      phase <= PH_LOAD;
      job   <= '0;
      step  <= '0;
    end else begin
      case (phase)
        PH_LOAD: begin
          phase <= PH_DIV;
          step  <= '0;
        end
        PH_DIV: begin
          if (step == 6'(DVD_W - 1)) begin
            step <= '0;
            job  <= job + 2'd1;
            phase <= (job == 2'd3) ? PH_TRIG : PH_LOAD;
          end else begin
            step <= step + 6'd1;
          end
        end
        PH_TRIG: begin
          if (step == 6'(sbcm_pkg::CORDIC_STEPS + 4)) begin
            phase <= PH_IDLE;
          end else begin
            step <= step + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // divider datapath and result capture
  always_ff @(posedge clk) begin
    if (phase == PH_LOAD) begin
      dvd <= prod;
      rem <= '0;
    end else if (phase == PH_DIV) begin
      dvd <= dvd_next;
      rem <= rem_next;
      if (step == 6'(DVD_W - 1)) begin
        edge_ang[job] <= dvd_next[31:0] - {1'b0, hw_sel};
      end
    end
    if (phase == PH_TRIG && t_valid && step >= 6'(sbcm_pkg::CORDIC_STEPS)) begin
      case (3'(step - 6'(sbcm_pkg::CORDIC_STEPS)))
        3'd0: sb_lon <= t_sin;
        3'd1: se_lon <= t_sin;
        3'd2: sb_lat <= t_sin;
        3'd3: se_lat <= t_sin;
        3'd4: begin
          cv <= t_cos;
          sv <= -t_sin;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    busy         = (phase != PH_IDLE);
    box.ok       = (cnt_lon != '0) && (cnt_lon <= sbcm_pkg::CNT_W'(sbcm_pkg::MAX_CELLS)) &&
                   (cnt_lat != '0) && (cnt_lat <= sbcm_pkg::CNT_W'(sbcm_pkg::MAX_CELLS)) &&
                   ({1'b0, idx_lon} < cnt_lon) && ({1'b0, idx_lat} < cnt_lat);
    box.last_lon = ({1'b0, idx_lon} + sbcm_pkg::CNT_W'(1)) == cnt_lon;
    box.last_lat = ({1'b0, idx_lat} + sbcm_pkg::CNT_W'(1)) == cnt_lat;
    box.sb_lon   = sb_lon;
    box.se_lon   = se_lon;
    box.sb_lat   = sb_lat;
    box.se_lat   = se_lat;
    box.cv       = cv;
    box.sv       = sv;
  end

endmodule
`default_nettype wire

/* sv/sky_box_cell_membership.sv */
// Sky box cell test: one word in per cycle while in_ready is high; the result word
// passes 30 rotation cells, two product stages and the output register.
// Sustained 1 word/cycle while in_ready is high. A stalled output stalls the
// whole pipe unless the product stage in front of it is empty.
// After reset and after each register write, in_ready stays low while edge sines
// are derived (four divide jobs, then the rotation pass).
`default_nettype none
module sky_box_cell_membership (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] object_lon,
  input  wire logic signed [31:0] object_lat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             inside_res,
  input  wire logic        wr_en,
  input  wire logic [3:0]  wr_index,
  input  wire logic [31:0] wr_data
);

  logic           busy;
  sbcm_pkg::box_t box;
  logic [31:0]    center_lon;

  sbcm_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .busy       (busy),
    .center_lon (center_lon),
    .box        (box)
  );

  logic out_free;
  logic adv;
  logic accept;
  logic a_v, b_v;
  logic lat_v, lon_v;
  logic signed [31:0] tl_s, tl_c, td_s, td_c;
  logic signed [31:0] y0, x0, z0;
  logic signed [63:0] p_xs, p_zc, p_xc, p_zs;
  logic lon_ok;
  logic signed [63:0] zs, xs;
  logic in_box;

  assign out_free = !out_valid || out_ready;
  assign adv      = out_free || !b_v;
  assign in_ready = adv && !busy;
  assign accept   = in_valid && in_ready;

  sbcm_cordic_chain u_lat (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (accept),
    .angle     (object_lat),
    .out_valid (lat_v),
    .sin_q     (tl_s),
    .cos_q     (tl_c)
  );

  sbcm_cordic_chain u_lon (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (accept),
    .angle     (object_lon - center_lon),
    .out_valid (lon_v),
    .sin_q     (td_s),
    .cos_q     (td_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        a_v <= lat_v && lon_v;
        b_v <= a_v;
      end
      if (out_free) begin
        out_valid <= b_v;
      end
    end
  end

  // stage A: project onto the rotated frame
  always_ff @(posedge clk) begin
    if (adv) begin
      y0 <= 32'((64'(td_s) * 64'(tl_c)) >>> 30);
      x0 <= 32'((64'(td_c) * 64'(tl_c)) >>> 30);
      z0 <= tl_s;
    end
  end

  // stage B: center latitude rotation products and the longitude check
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xs   <= 64'(x0) * 64'(box.sv);
      p_zc   <= 64'(z0) * 64'(box.cv);
      p_xc   <= 64'(x0) * 64'(box.cv);
      p_zs   <= 64'(z0) * 64'(box.sv);
      lon_ok <= sbcm_pkg::in_cell(64'(y0), box.sb_lon, box.se_lon, box.last_lon);
    end
  end

  always_comb begin
    zs     = (p_xs + p_zc) >>> 30;
    xs     = (p_xc - p_zs) >>> 30;
    in_box = box.ok && lon_ok && !xs[63] &&
             sbcm_pkg::in_cell(zs, box.sb_lat, box.se_lat, box.last_lat);
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      inside_res <= in_box;
    end
  end

endmodule
`default_nettype wire
